// ===== rtl/isc_pkg.sv =====
// ----------------------------------------------------------------------------
// isc_pkg
// Shared constants, types and register codes of the 3x3 cross sharpen filter.
// ----------------------------------------------------------------------------
package isc_pkg;

	// geometry limits
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int INROW_W    = ROW_W + 1;

	// pixel format
	localparam int CH_W     = 8;
	localparam int NUM_CH   = 4;
	localparam int CHANNELS = 4;
	localparam int PIX_W    = NUM_CH * CH_W;

	// configuration registers
	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(640);
	localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// output buffer
	localparam int OUT_W       = PIX_W + 1;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	// one channel of the 3x3 cross window
	typedef struct packed {
		logic [CH_W-1:0] ctr;
		logic [CH_W-1:0] up;
		logic [CH_W-1:0] left_px;
		logic [CH_W-1:0] right_px;
		logic [CH_W-1:0] below;
	} lane_win_t;

endpackage

// ===== rtl/isc_ram.sv =====
// ----------------------------------------------------------------------------
// isc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/isc_lane.sv =====
// ----------------------------------------------------------------------------
// isc_lane
// One channel of the sharpen kernel: 5*centre minus the four cross neighbours,
// clamped to the 8-bit range.
// ----------------------------------------------------------------------------
module isc_lane
	import isc_pkg::*;
(
	input  lane_win_t        win,
	output logic [CH_W-1:0]  result
);

	logic [CH_W+2:0]        ctr5;
	logic [CH_W+1:0]        nb_sum;
	logic signed [CH_W+3:0] diff;

	// 5*c as c*4 + c, neighbours summed in parallel
	assign ctr5   = {win.ctr, 2'b00} + {3'b000, win.ctr};
	assign nb_sum = ({2'b00, win.up} + {2'b00, win.left_px})
	              + ({2'b00, win.right_px} + {2'b00, win.below});
	assign diff   = $signed({1'b0, ctr5}) - $signed({2'b00, nb_sum});

	// clamp to 0..255
	always_comb begin
		if (diff < 0) begin
			result = '0;
		end else if (diff > $signed((CH_W+4)'(255))) begin
			result = '1;
		end else begin
			result = diff[CH_W-1:0];
		end
	end

endmodule

// ===== rtl/isc_fifo.sv =====
// ----------------------------------------------------------------------------
// isc_fifo
// Small output buffer that decouples the filter pipeline from the result
// stream; reports its fill level so the input side can reserve room.
// ----------------------------------------------------------------------------
module isc_fifo
	import isc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [OUT_W-1:0]      push_data,
	input  logic                  pop_ready,
	output logic                  pop_valid,
	output logic [OUT_W-1:0]      pop_data,
	output logic [FIFO_CNT_W-1:0] count
);

	logic [OUT_W-1:0]      mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  pop;

	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid & pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/image_sharpen_3x3_cross.sv =====
// ----------------------------------------------------------------------------
// image_sharpen_3x3_cross
// Streaming 3x3 cross sharpen filter on RGBA pixels in raster order.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and gives out one result word per
// clock in steady state, unless a stalled output fills the output buffer. The
// result for pixel (r,c) is computed when input pixel (r+1,c) arrives, so the
// result stream trails the input by one image row; after the last row,
// image_width drain words (tuser = 1) flush it, and the last of them carries
// tlast. The rate is set by the line stores: each is a RAM with one write and
// one registered read per clock (the centre line is held twice so that centre
// and right neighbour are read in the same cycle), and a four-word output
// buffer lets input continue while results wait. The line stores need no
// clearing after reset. A register write restarts the frame.
// ----------------------------------------------------------------------------
module image_sharpen_3x3_cross
	import isc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	// pixel input
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIX_W-1:0]     s_tdata,  // in_ch0, in_ch1, in_ch2, in_ch3
	input  logic                 s_tuser,  // mode
	// result output
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIX_W-1:0]     m_tdata,  // out_ch0, out_ch1, out_ch2, out_ch3
	output logic                 m_tlast
);

	// registers and frame counters
	logic [REG_W-1:0]   width_q;
	logic [REG_W-1:0]   height_q;
	logic [COL_W-1:0]   in_col_q;
	logic [INROW_W-1:0] in_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic [ROW_W-1:0]   out_row_q;

	logic [REG_W-1:0]   eff_w;
	logic [REG_W-1:0]   eff_h;
	logic               cfg_fire;
	logic               in_fire;
	logic               frame_in;
	logic               emit;
	logic               store;
	logic               adv_in;
	logic               in_col_end;
	logic               out_col_end;
	logic               last;
	logic [COL_W-1:0]   col;
	logic [PIX_W-1:0]   px_in;

	// stage 1: line store data returns
	logic               emit_s1;
	logic               store_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PIX_W-1:0]   below_s1;
	logic               up_en_s1;
	logic               left_en_s1;
	logic               right_en_s1;
	logic               last_s1;

	logic [PIX_W-1:0]   rd_ctr;
	logic [PIX_W-1:0]   rd_right;
	logic [PIX_W-1:0]   rd_up;
	logic [PIX_W-1:0]   ctr;
	logic [PIX_W-1:0]   right_px;
	logic [PIX_W-1:0]   up_px;
	logic [PIX_W-1:0]   left_q;
	logic [COL_W-1:0]   col_right_s1;

	// last line store writes, for read-during-write bypass
	logic               awr_q;
	logic [COL_W-1:0]   aaddr_q;
	logic [PIX_W-1:0]   adata_q;
	logic               bwr_q;
	logic [COL_W-1:0]   baddr_q;
	logic [PIX_W-1:0]   bdata_q;
	logic               a_we;
	logic               b_we;

	// stage 2: full window
	logic               res_s2;
	logic               last_s2;
	logic [PIX_W-1:0]   ctr_s2;
	logic [PIX_W-1:0]   up_s2;
	logic [PIX_W-1:0]   left_s2;
	logic [PIX_W-1:0]   right_s2;
	logic [PIX_W-1:0]   below_s2;

	logic [PIX_W-1:0]      res_px;
	logic [OUT_W-1:0]      fifo_out;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W:0]   occupancy;

	// effective geometry, clamped to the supported range
	always_comb begin
		if (width_q == '0) begin
			eff_w = REG_W'(1);
		end else if (width_q > REG_W'(MAX_WIDTH)) begin
			eff_w = REG_W'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = REG_W'(1);
		end else if (height_q > REG_W'(MAX_HEIGHT)) begin
			eff_h = REG_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	// handshakes; room is reserved for every result still in the pipeline
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;
	assign occupancy = {1'b0, fifo_cnt} + (FIFO_CNT_W+1)'(emit_s1) + (FIFO_CNT_W+1)'(res_s2);
	assign s_tready  = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));
	assign in_fire   = s_tvalid & s_tready;

	// word decode
	assign frame_in    = (in_row_q >= eff_h);
	assign emit        = in_fire & (s_tuser ? frame_in : (!frame_in && in_row_q != '0));
	assign store       = in_fire & !s_tuser & !frame_in & (in_row_q == '0);
	assign adv_in      = in_fire & !s_tuser & !frame_in;
	assign in_col_end  = (({1'b0, in_col_q} + REG_W'(1)) >= eff_w);
	assign out_col_end = (({1'b0, out_col_q} + REG_W'(1)) >= eff_w);
	assign last        = (({1'b0, out_row_q} + REG_W'(1)) >= eff_h) & out_col_end;
	assign col         = emit ? out_col_q : in_col_q;

	// incoming pixel, unused channels dropped
	always_comb begin
		px_in = '0;
		for (int k = 0; k < NUM_CH; k++) begin
			if (k < CHANNELS) begin
				px_in[k*CH_W +: CH_W] = s_tdata[k*CH_W +: CH_W];
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_fire || (emit && last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (emit) begin
				if (out_col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
			if (adv_in) begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1  <= 1'b0;
			store_s1 <= 1'b0;
		end else begin
			emit_s1  <= emit;
			store_s1 <= store;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1      <= col;
			below_s1    <= s_tuser ? '0 : px_in;
			up_en_s1    <= (out_row_q != '0);
			left_en_s1  <= (col != '0);
			right_en_s1 <= !out_col_end;
			last_s1     <= last;
		end
	end

	// line stores: centre line twice (centre and right reads), upper line once
	assign col_right_s1 = col_s1 + 1'b1;
	assign a_we         = emit_s1 | store_s1;
	assign b_we         = emit_s1;

	isc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_centre_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (col_s1),
		.wdata (below_s1),
		.re    (emit),
		.raddr (col),
		.rdata (rd_ctr)
	);

	isc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_right_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (col_s1),
		.wdata (below_s1),
		.re    (emit),
		.raddr (col + 1'b1),
		.rdata (rd_right)
	);

	isc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (col_s1),
		.wdata (ctr),
		.re    (emit),
		.raddr (col),
		.rdata (rd_up)
	);

	// bypass the write that landed in the same cycle as the read
	always_comb begin
		ctr      = (awr_q && aaddr_q == col_s1) ? adata_q : rd_ctr;
		right_px = (awr_q && aaddr_q == col_right_s1) ? adata_q : rd_right;
		up_px    = (bwr_q && baddr_q == col_s1) ? bdata_q : rd_up;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awr_q <= 1'b0;
			bwr_q <= 1'b0;
		end else begin
			awr_q <= a_we;
			bwr_q <= b_we;
		end
	end

	always_ff @(posedge clk) begin
		aaddr_q <= col_s1;
		adata_q <= below_s1;
		baddr_q <= col_s1;
		bdata_q <= ctr;
	end

	// left neighbour is the previous centre
	always_ff @(posedge clk) begin
		if (emit_s1) begin
			left_q <= ctr;
		end
	end

	// stage 2: window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else begin
			res_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s1) begin
			last_s2  <= last_s1;
			ctr_s2   <= ctr;
			up_s2    <= up_en_s1 ? up_px : '0;
			left_s2  <= left_en_s1 ? left_q : '0;
			right_s2 <= right_en_s1 ? right_px : '0;
			below_s2 <= below_s1;
		end
	end

	// one kernel lane per channel
	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		if (k < CHANNELS) begin : g_on
			lane_win_t win;
			assign win.ctr      = ctr_s2[k*CH_W +: CH_W];
			assign win.up       = up_s2[k*CH_W +: CH_W];
			assign win.left_px  = left_s2[k*CH_W +: CH_W];
			assign win.right_px = right_s2[k*CH_W +: CH_W];
			assign win.below    = below_s2[k*CH_W +: CH_W];

			isc_lane u_lane (
				.win    (win),
				.result (res_px[k*CH_W +: CH_W])
			);
		end else begin : g_off
			assign res_px[k*CH_W +: CH_W] = '0;
		end
	end

	// merge lanes and frame marker into the output buffer
	isc_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_s2),
		.push_data ({last_s2, res_px}),
		.pop_ready (m_tready),
		.pop_valid (m_tvalid),
		.pop_data  (fifo_out),
		.count     (fifo_cnt)
	);

	assign m_tdata = fifo_out[PIX_W-1:0];
	assign m_tlast = fifo_out[PIX_W];

endmodule
